>>> sv/mgcc_pkg.sv
`default_nettype none

package mgcc_pkg;

    localparam int CH_W    = 8;
    localparam int COORD_W = 10;
    localparam int CNT_W   = 21;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Class thresholds.
    localparam logic [11:0] YEL_R_MIN     = 12'd96;
    localparam logic [11:0] YEL_B_MAX     = 12'd32;
    localparam logic [11:0] RED_R_MIN     = 12'd224;
    localparam logic [11:0] RED_B_MAX     = 12'd64;
    localparam logic [11:0] RED_G_MAX     = 12'd96;
    localparam logic [11:0] PUR_MIN       = 12'd128;
    localparam logic [7:0]  NEUTRAL_SPREAD = 8'd20;
    localparam logic [7:0]  GRAY_LOW      = 8'd48;
    localparam logic [7:0]  GRAY_HIGH     = 8'd80;
    localparam logic [7:0]  WHITE_LOW     = 8'd175;

    localparam logic [7:0]           MOTION_LIMIT_RST = 8'd30;
    localparam logic [CNT_W-1:0]     ANCHOR_COUNT_RST = 21'd100;
    localparam logic [COORD_W-1:0]   ROW_SKIP_RST     = 10'd75;

    typedef enum logic [1:0] {
        CFG_MOTION_LIMIT = 2'd0,
        CFG_ANCHOR_COUNT = 2'd1,
        CFG_ROW_SKIP     = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        CLS_NONE,
        CLS_YELLOW,
        CLS_RED,
        CLS_PURPLE,
        CLS_GRAY,
        CLS_WHITE
    } cls_t;

    typedef struct packed {
        logic [CH_W-1:0]    cur_blue;
        logic [CH_W-1:0]    cur_green;
        logic [CH_W-1:0]    cur_red;
        logic [CH_W-1:0]    prev_blue;
        logic [CH_W-1:0]    prev_green;
        logic [CH_W-1:0]    prev_red;
        logic [COORD_W-1:0] pixel_row;
        logic [COORD_W-1:0] pixel_col;
        logic               frame_first;
        logic               frame_last;
    } pixel_t;

    typedef struct packed {
        logic [CNT_W-1:0]   yellow_total;
        logic [CNT_W-1:0]   red_total;
        logic [CNT_W-1:0]   purple_total;
        logic [CNT_W-1:0]   gray_total;
        logic [CNT_W-1:0]   white_total;
        logic               anchor_found;
        logic [COORD_W-1:0] anchor_col;
        logic [COORD_W-1:0] anchor_row;
    } result_t;

    // Classified pixel handed from the front end to the accumulator.
    typedef struct packed {
        cls_t               cls;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] quot;
        logic               first;
        logic               last;
    } cls_item_t;

    // Front-end status seen by the flow control.
    typedef struct packed {
        logic last_pending;
    } front_stat_t;

    function automatic logic [CH_W-1:0] absdiff8(input logic [CH_W-1:0] a,
                                                 input logic [CH_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c == CNT_MAX) ? c : (c + 1'b1);
    endfunction

    function automatic cls_t classify_pixel(input logic [CH_W-1:0] r,
                                            input logic [CH_W-1:0] g,
                                            input logic [CH_W-1:0] b);
        logic [11:0] r12;
        logic [11:0] g12;
        logic [11:0] b12;
        logic        yel;
        logic        red;
        logic        pur;
        logic        neutral;
        logic        gray;
        logic        white;
        r12 = {4'b0, r};
        g12 = {4'b0, g};
        b12 = {4'b0, b};
        // 3(r-b) > r is rewritten as 2r > 3b so it never goes negative.
        yel = (r12 > YEL_R_MIN) && ((r12 << 1) > (b12 * 12'd3)) && (b12 < YEL_B_MAX)
              && ((g12 * 12'd10) < (r12 * 12'd9)) && ((g12 * 12'd5) > (r12 * 12'd3));
        red = (r12 > RED_R_MIN) && (b12 < RED_B_MAX) && (g12 < RED_G_MAX);
        pur = (r12 > PUR_MIN) && (b12 > PUR_MIN) && ((g12 << 2) < (r12 * 12'd3))
              && ((g12 << 1) > r12);
        neutral = (absdiff8(r, g) < NEUTRAL_SPREAD) && (absdiff8(r, b) < NEUTRAL_SPREAD)
                  && (absdiff8(g, b) < NEUTRAL_SPREAD);
        gray = (r > GRAY_LOW) && (g > GRAY_LOW) && (b > GRAY_LOW)
               && (r < GRAY_HIGH) && (g < GRAY_HIGH) && (b < GRAY_HIGH);
        white = (r > WHITE_LOW) && (g > WHITE_LOW) && (b > WHITE_LOW);
        if (yel)
            return CLS_YELLOW;
        else if (red)
            return CLS_RED;
        else if (pur)
            return CLS_PURPLE;
        else if (neutral && gray)
            return CLS_GRAY;
        else if (neutral && white)
            return CLS_WHITE;
        else
            return CLS_NONE;
    endfunction

endpackage

`default_nettype wire

>>> sv/mgcc_pixel_if.sv
`default_nettype none

interface mgcc_pixel_if;
    import mgcc_pkg::*;

    logic   valid;
    logic   ready;
    pixel_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> sv/mgcc_result_if.sv
`default_nettype none

interface mgcc_result_if;
    import mgcc_pkg::*;

    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> sv/mgcc_front.sv
`default_nettype none

module mgcc_front
    import mgcc_pkg::*;
#(
    parameter int LANES    = 4,
    parameter int MAX_ROWS = 1024,
    parameter int MAX_COLS = 1024
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    mgcc_pixel_if.sink        pix,
    input  wire logic         advance,
    input  wire logic [7:0]   motion_limit,
    output logic              item_valid,
    output cls_item_t         item,
    output front_stat_t       stat
);

    localparam int          QSH     = 20;
    localparam int          RECIP   = (1 << QSH) / LANES;
    localparam logic [12:0] ROW_LIM = 13'(MAX_ROWS);
    localparam logic [12:0] COL_LIM = 13'(MAX_COLS);

    logic      s1_valid_reg;
    pixel_t    s1_pix_reg;
    logic      s2_valid_reg;
    cls_item_t s2_item_reg;

    logic      still;
    logic      in_region;
    logic [29:0] qprod;
    cls_item_t s2_item_next;

    assign pix.ready = advance;

    always_comb
    begin
        still = (absdiff8(s1_pix_reg.cur_blue, s1_pix_reg.prev_blue) < motion_limit)
                && (absdiff8(s1_pix_reg.cur_green, s1_pix_reg.prev_green) < motion_limit)
                && (absdiff8(s1_pix_reg.cur_red, s1_pix_reg.prev_red) < motion_limit);
        in_region = ({3'b0, s1_pix_reg.pixel_row} < ROW_LIM)
                    && ({3'b0, s1_pix_reg.pixel_col} < COL_LIM);
        // Quotient by the lane count through a fixed reciprocal; it can be one short.
        qprod = 30'(s1_pix_reg.pixel_row) * 30'(RECIP);
        s2_item_next.cls = (still && in_region)
            ? classify_pixel(s1_pix_reg.cur_red, s1_pix_reg.cur_green, s1_pix_reg.cur_blue)
            : CLS_NONE;
        s2_item_next.row   = s1_pix_reg.pixel_row;
        s2_item_next.col   = s1_pix_reg.pixel_col;
        s2_item_next.quot  = qprod[QSH+COORD_W-1:QSH];
        s2_item_next.first = s1_pix_reg.frame_first;
        s2_item_next.last  = s1_pix_reg.frame_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= pix.valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_pix_reg  <= pix.data;
            s2_item_reg <= s2_item_next;
        end
    end

    assign item_valid = s2_valid_reg;
    assign item       = s2_item_reg;
    assign stat.last_pending = (s1_valid_reg && s1_pix_reg.frame_last)
                               || (s2_valid_reg && s2_item_reg.last);

endmodule

`default_nettype wire

>>> sv/mgcc_accum.sv
`default_nettype none

module mgcc_accum
    import mgcc_pkg::*;
#(
    parameter int LANES = 4
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    input  wire cls_item_t          item,
    input  wire front_stat_t        front_stat,
    input  wire logic [CNT_W-1:0]   anchor_count,
    input  wire logic [COORD_W-1:0] row_skip,
    output logic                    advance,
    mgcc_result_if.source           res
);

    localparam int LW = (LANES > 1) ? $clog2(LANES) : 1;

    // Lane stage.
    logic               s3_valid_reg;
    cls_t               s3_cls_reg;
    logic [COORD_W-1:0] s3_row_reg;
    logic [COORD_W-1:0] s3_col_reg;
    logic [LW-1:0]      s3_lane_reg;
    logic               s3_first_reg;
    logic               s3_last_reg;

    logic [13:0] qmul;
    logic [13:0] rem;
    logic [13:0] lane_full;

    // Frame counters.
    logic [CNT_W-1:0]   yel_reg, yel_next;
    logic [CNT_W-1:0]   red_reg, red_next;
    logic [CNT_W-1:0]   pur_reg, pur_next;
    logic [CNT_W-1:0]   gray_reg, gray_next;
    logic [CNT_W-1:0]   white_reg, white_next;
    logic [CNT_W-1:0]   lane_cnt_reg [LANES];
    logic [CNT_W-1:0]   lane_cnt_next [LANES];
    logic               lane_anch_reg [LANES];
    logic               lane_anch_next [LANES];
    logic [COORD_W-1:0] lane_arow_reg [LANES];
    logic [COORD_W-1:0] lane_arow_next [LANES];
    logic               best_found_reg, best_found_next;
    logic [COORD_W-1:0] best_row_reg, best_row_next;
    logic [COORD_W-1:0] best_col_reg, best_col_next;
    logic [LW-1:0]      best_lane_reg, best_lane_next;

    logic               sel_anch;
    logic [CNT_W-1:0]   sel_cnt;
    logic [COORD_W-1:0] sel_arow;
    logic               count_ok;
    logic [CNT_W-1:0]   new_cnt;
    logic               set_anchor;
    logic               better;

    logic    done_reg;
    logic    res_valid_reg;
    result_t res_data_reg;

    assign advance = !(res_valid_reg && !res.ready
                       && (front_stat.last_pending || (s3_valid_reg && s3_last_reg)
                           || done_reg));

    always_comb
    begin
        qmul      = 14'(item.quot) * 14'(LANES);
        rem       = {4'b0, item.row} - qmul;
        lane_full = (rem >= 14'(LANES)) ? (rem - 14'(LANES)) : rem;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (advance)
            s3_valid_reg <= item_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s3_cls_reg   <= item.cls;
            s3_row_reg   <= item.row;
            s3_col_reg   <= item.col;
            s3_lane_reg  <= lane_full[LW-1:0];
            s3_first_reg <= item.first;
            s3_last_reg  <= item.last;
        end
    end

    always_comb
    begin
        yel_next        = s3_first_reg ? '0 : yel_reg;
        red_next        = s3_first_reg ? '0 : red_reg;
        pur_next        = s3_first_reg ? '0 : pur_reg;
        gray_next       = s3_first_reg ? '0 : gray_reg;
        white_next      = s3_first_reg ? '0 : white_reg;
        best_found_next = s3_first_reg ? 1'b0 : best_found_reg;
        best_row_next   = s3_first_reg ? '0 : best_row_reg;
        best_col_next   = s3_first_reg ? '0 : best_col_reg;
        best_lane_next  = s3_first_reg ? '0 : best_lane_reg;
        for (int i = 0; i < LANES; i++)
        begin
            lane_cnt_next[i]  = s3_first_reg ? '0 : lane_cnt_reg[i];
            lane_anch_next[i] = s3_first_reg ? 1'b0 : lane_anch_reg[i];
            lane_arow_next[i] = s3_first_reg ? '0 : lane_arow_reg[i];
        end

        sel_cnt  = s3_first_reg ? '0 : lane_cnt_reg[s3_lane_reg];
        sel_anch = s3_first_reg ? 1'b0 : lane_anch_reg[s3_lane_reg];
        sel_arow = s3_first_reg ? '0 : lane_arow_reg[s3_lane_reg];

        // A lane that holds an anchor counts again only past the skip window.
        count_ok   = !sel_anch
                     || ({1'b0, s3_row_reg} > ({1'b0, sel_arow} + {1'b0, row_skip}));
        new_cnt    = count_ok ? sat_inc(sel_cnt) : sel_cnt;
        set_anchor = !sel_anch && (new_cnt > anchor_count);
        better     = !best_found_next || (s3_row_reg < best_row_next)
                     || ((s3_row_reg == best_row_next) && (s3_lane_reg < best_lane_next));

        case (s3_cls_reg)
            CLS_YELLOW: yel_next  = sat_inc(yel_next);
            CLS_RED:    red_next  = sat_inc(red_next);
            CLS_PURPLE: pur_next  = sat_inc(pur_next);
            CLS_GRAY:   gray_next = sat_inc(gray_next);
            CLS_WHITE:
            begin
                lane_cnt_next[s3_lane_reg] = new_cnt;
                // The running sum rises only when a lane count rises, and it saturates at the top.
                if (count_ok && (sel_cnt != CNT_MAX))
                    white_next = sat_inc(white_next);
                if (set_anchor)
                begin
                    lane_anch_next[s3_lane_reg] = 1'b1;
                    lane_arow_next[s3_lane_reg] = s3_row_reg;
                    if (better)
                    begin
                        best_found_next = 1'b1;
                        best_row_next   = s3_row_reg;
                        best_col_next   = s3_col_reg;
                        best_lane_next  = s3_lane_reg;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            yel_reg        <= '0;
            red_reg        <= '0;
            pur_reg        <= '0;
            gray_reg       <= '0;
            white_reg      <= '0;
            best_found_reg <= 1'b0;
            best_row_reg   <= '0;
            best_col_reg   <= '0;
            best_lane_reg  <= '0;
            for (int i = 0; i < LANES; i++)
            begin
                lane_cnt_reg[i]  <= '0;
                lane_anch_reg[i] <= 1'b0;
                lane_arow_reg[i] <= '0;
            end
        end
        else if (advance && s3_valid_reg)
        begin
            yel_reg        <= yel_next;
            red_reg        <= red_next;
            pur_reg        <= pur_next;
            gray_reg       <= gray_next;
            white_reg      <= white_next;
            best_found_reg <= best_found_next;
            best_row_reg   <= best_row_next;
            best_col_reg   <= best_col_next;
            best_lane_reg  <= best_lane_next;
            for (int i = 0; i < LANES; i++)
            begin
                lane_cnt_reg[i]  <= lane_cnt_next[i];
                lane_anch_reg[i] <= lane_anch_next[i];
                lane_arow_reg[i] <= lane_arow_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
                done_reg <= s3_valid_reg && s3_last_reg;
            if (advance && done_reg)
                res_valid_reg <= 1'b1;
            else if (res.ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && done_reg)
        begin
            res_data_reg.yellow_total <= yel_reg;
            res_data_reg.red_total    <= red_reg;
            res_data_reg.purple_total <= pur_reg;
            res_data_reg.gray_total   <= gray_reg;
            res_data_reg.white_total  <= white_reg;
            res_data_reg.anchor_found <= best_found_reg;
            res_data_reg.anchor_col   <= best_col_reg;
            res_data_reg.anchor_row   <= best_row_reg;
        end
    end

    assign res.valid = res_valid_reg;
    assign res.data  = res_data_reg;

endmodule

`default_nettype wire

>>> sv/motion_gated_color_class_counter_unit.sv
// Motion-gated color class counter.
// Pixels arrive on the pix channel, one word per pixel, with the previous-frame
// value, row, column and frame start/end flags. A pixel whose channels all moved
// less than the motion limit is classed as yellow, red, purple, gray or white and
// counted; white is counted per row lane and each lane may latch an anchor.
// After the word marked frame_last, one result word with the totals and the
// topmost anchor leaves on the res channel.
// Throughput is one pixel per clock unless the flow control holds the pipeline:
// a three-stage pipeline (input register, classify register, lane register)
// feeds the counter updates, then a result register. A result word becomes valid
// after its last pixel has passed those stages, the counters and the done flag.
// The cfg port writes motion_limit, anchor_count and row_skip by index; it is
// meant to be written while the block is idle.
// Reset clears all counters, lane anchors and pipeline valid bits, and loads the
// register defaults (30, 100, 75); no clearing pass is needed.
// When the receiver stalls, the block keeps taking pixels until a frame_last
// word is in flight behind the waiting result; only then does pix.ready drop.
`default_nettype none

module motion_gated_color_class_counter_unit
    import mgcc_pkg::*;
#(
    parameter int LANES    = 4,
    parameter int MAX_ROWS = 1024,
    parameter int MAX_COLS = 1024
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    mgcc_pixel_if.sink        pix,
    mgcc_result_if.source     res,
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [CNT_W-1:0] cfg_data
);

    logic [7:0]         motion_limit_reg;
    logic [CNT_W-1:0]   anchor_count_reg;
    logic [COORD_W-1:0] row_skip_reg;

    logic        advance;
    logic        item_valid;
    cls_item_t   item;
    front_stat_t front_stat;

    // Configuration registers; an index outside the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            motion_limit_reg <= MOTION_LIMIT_RST;
            anchor_count_reg <= ANCHOR_COUNT_RST;
            row_skip_reg     <= ROW_SKIP_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MOTION_LIMIT: motion_limit_reg <= cfg_data[7:0];
                CFG_ANCHOR_COUNT: anchor_count_reg <= cfg_data;
                CFG_ROW_SKIP:     row_skip_reg     <= cfg_data[COORD_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register, motion gate, region check and color classification.
    mgcc_front #(
        .LANES    (LANES),
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .pix          (pix),
        .advance      (advance),
        .motion_limit (motion_limit_reg),
        .item_valid   (item_valid),
        .item         (item),
        .stat         (front_stat)
    );

    // Lane selection, counters, anchors, result register and flow control.
    mgcc_accum #(
        .LANES (LANES)
    ) u_accum (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item         (item),
        .front_stat   (front_stat),
        .anchor_count (anchor_count_reg),
        .row_skip     (row_skip_reg),
        .advance      (advance),
        .res          (res)
    );

    // The pipeline only holds while the result register is blocked.
    assert property (@(posedge clk) disable iff (!rst_n)
        !pix.ready |-> (res.valid && !res.ready))
        else $error("input stalled without a blocked result");

    // A held pipeline never loads a new result word.
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(res.data))
        else $error("result changed while the pipeline was held");

    // Without an anchor the anchor position reads as zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.data.anchor_found)
            |-> (res.data.anchor_col == '0 && res.data.anchor_row == '0))
        else $error("anchor position set without an anchor");

endmodule

`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import mgcc_pkg::*;

    // The block is built with its default geometry, and the predictor below
    // uses the same numbers.
    localparam int LANES       = 4;
    localparam int MAX_ROWS    = 1024;
    localparam int MAX_COLS    = 1024;
    localparam int CNT_TOP     = 2 ** CNT_W - 1;
    localparam int CYCLE_LIMIT = 400000;

    // Color families that the pixel painter aims at. A neutral pixel near the
    // gray and white borders is its own family so that the edges get hit.
    typedef enum int {
        PAINT_YELLOW,
        PAINT_RED,
        PAINT_PURPLE,
        PAINT_GRAY,
        PAINT_WHITE,
        PAINT_NEUTRAL_EDGE,
        PAINT_ANY
    } paint_t;

    logic clk;
    logic rst_n;
    logic             cfg_we;
    logic [1:0]       cfg_index;
    logic [CNT_W-1:0] cfg_data;

    mgcc_pixel_if  pix_if ();
    mgcc_result_if res_if ();

    motion_gated_color_class_counter_unit #(
        .LANES    (LANES),
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix       (pix_if),
        .res       (res_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Register copies held by the predictor. They start at the reset values
    // and follow every write made through apply_settings.
    int unsigned motion_limit_q = 30;
    int unsigned anchor_count_q = 100;
    int unsigned row_skip_q     = 75;

    // Frame counters and lane anchors as the block should hold them.
    int unsigned yellow_n;
    int unsigned red_n;
    int unsigned purple_n;
    int unsigned gray_n;
    int unsigned lane_white[LANES];
    bit          lane_anchored[LANES];
    int unsigned lane_anchor_col[LANES];
    int unsigned lane_anchor_row[LANES];

    // Frame totals that are owed by the block, oldest first.
    result_t expected_totals[$];

    int send_idle_pct;
    int recv_stall_pct;
    int mismatches;
    int pixels_sent;
    int totals_checked;
    int settings_applied;
    int cycles_run;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The watchdog ends a run that hangs, for instance when a frame end never
    // produces its totals word.
    initial begin
        while (cycles_run < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles_run++;
        end
        $display("motion_gated_color_class_counter_unit verification failed");
        $finish;
    end

    function automatic int unsigned bump(input int unsigned c);
        return (c < CNT_TOP) ? c + 1 : c;
    endfunction

    function automatic int channel_delta(input int a, input int b);
        return (a > b) ? a - b : b - a;
    endfunction

    // Predictor: applies one accepted pixel word to the frame state and, on a
    // frame end, queues the totals word that the block owes for it.
    task automatic tally_pixel(input pixel_t p);
        int          r;
        int          g;
        int          b;
        int unsigned row;
        int unsigned col;
        int unsigned lane;
        int unsigned white_sum;
        bit          found;
        int unsigned top_col;
        int unsigned top_row;
        bit          still;
        result_t     want;
        r   = int'(p.cur_red);
        g   = int'(p.cur_green);
        b   = int'(p.cur_blue);
        row = 32'(p.pixel_row);
        col = 32'(p.pixel_col);
        if (p.frame_first) begin
            yellow_n = 0;
            red_n    = 0;
            purple_n = 0;
            gray_n   = 0;
            for (int l = 0; l < LANES; l++) begin
                lane_white[l]      = 0;
                lane_anchored[l]   = 1'b0;
                lane_anchor_col[l] = 0;
                lane_anchor_row[l] = 0;
            end
        end
        // A pixel is still only if every channel moved by less than the limit,
        // so a limit of zero lets nothing through.
        still = channel_delta(b, int'(p.prev_blue)) < int'(motion_limit_q)
                && channel_delta(g, int'(p.prev_green)) < int'(motion_limit_q)
                && channel_delta(r, int'(p.prev_red)) < int'(motion_limit_q);
        if (row < MAX_ROWS && col < MAX_COLS && still) begin
            if (r > 96 && 3 * (r - b) > r && b < 32 && 10 * g < 9 * r && 5 * g > 3 * r) begin
                yellow_n = bump(yellow_n);
            end
            else if (r > 224 && b < 64 && g < 96) begin
                red_n = bump(red_n);
            end
            else if (r > 128 && b > 128 && 4 * g < 3 * r && 2 * g > r) begin
                purple_n = bump(purple_n);
            end
            else if (channel_delta(r, g) < 20 && channel_delta(r, b) < 20
                     && channel_delta(g, b) < 20) begin
                if (r > 48 && g > 48 && b > 48 && r < 80 && g < 80 && b < 80) begin
                    gray_n = bump(gray_n);
                end
                else if (r > 175 && g > 175 && b > 175) begin
                    // Once a lane is anchored, white counts again only on rows
                    // beyond the skip distance below the anchor.
                    lane = row % LANES;
                    if (!lane_anchored[lane] || row > lane_anchor_row[lane] + row_skip_q) begin
                        lane_white[lane] = bump(lane_white[lane]);
                    end
                    if (!lane_anchored[lane] && lane_white[lane] > anchor_count_q) begin
                        lane_anchored[lane]   = 1'b1;
                        lane_anchor_col[lane] = col;
                        lane_anchor_row[lane] = row;
                    end
                end
            end
        end
        if (p.frame_last) begin
            white_sum = 0;
            found     = 1'b0;
            top_col   = 0;
            top_row   = 0;
            // The topmost anchor wins; on a tie the lower lane is kept because
            // only a strictly smaller row replaces it.
            for (int l = 0; l < LANES; l++) begin
                white_sum += lane_white[l];
                if (white_sum > CNT_TOP) begin
                    white_sum = CNT_TOP;
                end
                if (lane_anchored[l] && (!found || lane_anchor_row[l] < top_row)) begin
                    found   = 1'b1;
                    top_col = lane_anchor_col[l];
                    top_row = lane_anchor_row[l];
                end
            end
            want.yellow_total = CNT_W'(yellow_n);
            want.red_total    = CNT_W'(red_n);
            want.purple_total = CNT_W'(purple_n);
            want.gray_total   = CNT_W'(gray_n);
            want.white_total  = CNT_W'(white_sum);
            want.anchor_found = found;
            want.anchor_col   = COORD_W'(top_col);
            want.anchor_row   = COORD_W'(top_row);
            expected_totals.push_back(want);
        end
    endtask

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    task automatic check_totals(input result_t got);
        result_t want;
        if (expected_totals.size() == 0) begin
            $error("totals word arrived with no frame end pending");
            mismatches++;
            return;
        end
        want = expected_totals.pop_front();
        totals_checked++;
        compare_field("yellow_total", 32'(want.yellow_total), 32'(got.yellow_total));
        compare_field("red_total", 32'(want.red_total), 32'(got.red_total));
        compare_field("purple_total", 32'(want.purple_total), 32'(got.purple_total));
        compare_field("gray_total", 32'(want.gray_total), 32'(got.gray_total));
        compare_field("white_total", 32'(want.white_total), 32'(got.white_total));
        compare_field("anchor_found", 32'(want.anchor_found), 32'(got.anchor_found));
        compare_field("anchor_col", 32'(want.anchor_col), 32'(got.anchor_col));
        compare_field("anchor_row", 32'(want.anchor_row), 32'(got.anchor_row));
    endtask

    // Result side: a word is taken at an edge where valid and ready were both
    // high before the edge. Ready for the next cycle is then drawn against the
    // stall rate of the current phase.
    always @(posedge clk) begin
        if (rst_n && res_if.valid && res_if.ready) begin
            check_totals(res_if.data);
        end
        res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Sends one pixel word. Idle cycles go before it at the sender's rate;
    // valid stays high after the handshake so that words can go back to back,
    // and settle_pipeline or an idle pick in the next call drops it.
    task automatic send_pixel(input pixel_t p);
        while ($urandom_range(99) < send_idle_pct) begin
            pix_if.valid <= 1'b0;
            @(posedge clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.data  <= p;
        do
            @(posedge clk);
        while (!pix_if.ready);
        tally_pixel(p);
        pixels_sent++;
    endtask

    // Waits until every owed totals word is in, then lets the pipeline empty
    // out behind it, since pixels without a frame end leave no trace.
    task automatic settle_pipeline();
        pix_if.valid <= 1'b0;
        while (expected_totals.size() != 0) begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    // Writes all three registers on consecutive edges. The caller makes sure
    // the block is idle.
    task automatic apply_settings(input logic [7:0] limit, input logic [CNT_W-1:0] anchor,
                                  input logic [COORD_W-1:0] skip);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MOTION_LIMIT;
        cfg_data  <= CNT_W'(limit);
        @(posedge clk);
        cfg_index <= CFG_ANCHOR_COUNT;
        cfg_data  <= anchor;
        @(posedge clk);
        cfg_index <= CFG_ROW_SKIP;
        cfg_data  <= CNT_W'(skip);
        @(posedge clk);
        cfg_we <= 1'b0;
        motion_limit_q = 32'(limit);
        anchor_count_q = 32'(anchor);
        row_skip_q     = 32'(skip);
        settings_applied++;
    endtask

    function automatic pixel_t pixel_of(input int r, input int g, input int b,
                                        input int pr, input int pg, input int pb,
                                        input int row, input int col,
                                        input bit is_first, input bit is_last);
        pixel_t p;
        p.cur_red     = CH_W'(r);
        p.cur_green   = CH_W'(g);
        p.cur_blue    = CH_W'(b);
        p.prev_red    = CH_W'(pr);
        p.prev_green  = CH_W'(pg);
        p.prev_blue   = CH_W'(pb);
        p.pixel_row   = COORD_W'(row);
        p.pixel_col   = COORD_W'(col);
        p.frame_first = is_first;
        p.frame_last  = is_last;
        return p;
    endfunction

    // Picks a color inside the chosen family. Gray and white keep green and blue
    // within 9 of red so that they stay neutral.
    function automatic void paint(input paint_t kind, output int r, output int g,
                                  output int b);
        int edge_pick;
        case (kind)
            PAINT_YELLOW: begin
                r = $urandom_range(97, 255);
                b = $urandom_range(0, 31);
                g = $urandom_range(3 * r / 5 + 1, (9 * r - 1) / 10);
            end
            PAINT_RED: begin
                r = $urandom_range(225, 255);
                g = $urandom_range(0, 95);
                b = $urandom_range(0, 63);
            end
            PAINT_PURPLE: begin
                r = $urandom_range(129, 255);
                b = $urandom_range(129, 255);
                g = $urandom_range(r / 2 + 1, (3 * r - 1) / 4);
            end
            PAINT_GRAY: begin
                r = $urandom_range(49, 79);
                g = $urandom_range((r - 9 < 49) ? 49 : r - 9, (r + 9 > 79) ? 79 : r + 9);
                b = $urandom_range((r - 9 < 49) ? 49 : r - 9, (r + 9 > 79) ? 79 : r + 9);
            end
            PAINT_WHITE: begin
                r = $urandom_range(176, 255);
                g = $urandom_range((r - 9 < 176) ? 176 : r - 9, (r + 9 > 255) ? 255 : r + 9);
                b = $urandom_range((r - 9 < 176) ? 176 : r - 9, (r + 9 > 255) ? 255 : r + 9);
            end
            PAINT_NEUTRAL_EDGE: begin
                edge_pick = $urandom_range(0, 5);
                r = (edge_pick == 0) ? 48 : (edge_pick == 1) ? 49 : (edge_pick == 2) ? 79 :
                    (edge_pick == 3) ? 80 : (edge_pick == 4) ? 175 : 176;
                g = r + $urandom_range(0, 2) - 1;
                b = r + $urandom_range(0, 2) - 1;
            end
            default: begin
                r = $urandom_range(0, 255);
                g = $urandom_range(0, 255);
                b = $urandom_range(0, 255);
            end
        endcase
    endfunction

    // Moves a channel by d in a random direction, folding back into range.
    function automatic int nudge(input int c, input int d);
        int v;
        v = $urandom_range(1) ? c + d : c - d;
        if (v > 255) v = c - d;
        if (v < 0) v = c + d;
        if (v > 255) v = 255;
        return v;
    endfunction

    // A random pixel: most are still within the current limit, some sit right
    // on the limit, and the rest have an unrelated previous value.
    function automatic pixel_t random_pixel();
        int     r;
        int     g;
        int     b;
        int     pr;
        int     pg;
        int     pb;
        int     lim;
        int     mode;
        int     row;
        int     col;
        paint_t kind;
        kind = paint_t'($urandom_range(0, 6));
        paint(kind, r, g, b);
        lim  = motion_limit_q;
        mode = $urandom_range(0, 9);
        if (mode < 6) begin
            pr = nudge(r, (lim == 0) ? 0 : $urandom_range(0, lim - 1));
            pg = nudge(g, (lim == 0) ? 0 : $urandom_range(0, lim - 1));
            pb = nudge(b, (lim == 0) ? 0 : $urandom_range(0, lim - 1));
        end
        else if (mode < 8) begin
            pr = nudge(r, (lim == 0) ? 0 : lim - $urandom_range(0, 1));
            pg = nudge(g, (lim == 0) ? 0 : lim - $urandom_range(0, 1));
            pb = nudge(b, (lim == 0) ? 0 : lim - $urandom_range(0, 1));
        end
        else begin
            pr = $urandom_range(0, 255);
            pg = $urandom_range(0, 255);
            pb = $urandom_range(0, 255);
        end
        // Rows stay mostly in a small band so that lanes fill up and anchors
        // form; the full range still shows up now and then.
        mode = $urandom_range(0, 19);
        row  = (mode < 15) ? $urandom_range(0, 15) :
               (mode < 19) ? $urandom_range(0, 1023) : (mode[0] ? 1023 : 0);
        col  = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(0, 1023);
        return pixel_of(r, g, b, pr, pg, pb, row, col, 1'b0, 1'b0);
    endfunction

    // One of each color class with the reset settings, the motion gate on both
    // sides of the limit, every field at its top value, and a second frame end
    // that must repeat the totals because nothing cleared them.
    task automatic test_class_picks();
        send_pixel(pixel_of(0, 0, 0, 0, 0, 0, 0, 0, 1'b1, 1'b0));
        send_pixel(pixel_of(200, 150, 10, 200, 150, 10, 1, 2, 1'b0, 1'b0));
        send_pixel(pixel_of(255, 0, 0, 250, 5, 3, 2, 3, 1'b0, 1'b0));
        send_pixel(pixel_of(200, 120, 200, 200, 120, 200, 3, 4, 1'b0, 1'b0));
        send_pixel(pixel_of(64, 64, 64, 64, 64, 64, 4, 5, 1'b0, 1'b0));
        send_pixel(pixel_of(255, 255, 255, 255, 255, 255, 1023, 1023, 1'b0, 1'b0));
        send_pixel(pixel_of(200, 200, 200, 200, 230, 200, 5, 6, 1'b0, 1'b0));
        send_pixel(pixel_of(200, 200, 200, 200, 229, 200, 5, 7, 1'b0, 1'b0));
        send_pixel(pixel_of(255, 255, 255, 0, 0, 0, 1023, 1023, 1'b0, 1'b1));
        send_pixel(pixel_of(10, 200, 90, 10, 200, 90, 6, 8, 1'b0, 1'b1));
        settle_pipeline();
    endtask

    // With a zero anchor count every lane anchors on its first white pixel.
    // Two anchors land on column zero, a repeat on the anchor row is skipped,
    // and the frame end must report the topmost anchor.
    task automatic test_anchor_positions();
        apply_settings(8'd30, '0, '0);
        send_pixel(pixel_of(220, 220, 220, 220, 220, 220, 4, 0, 1'b1, 1'b0));
        send_pixel(pixel_of(220, 220, 220, 220, 220, 220, 4, 9, 1'b0, 1'b0));
        send_pixel(pixel_of(220, 220, 220, 220, 220, 220, 9, 3, 1'b0, 1'b0));
        send_pixel(pixel_of(220, 220, 220, 220, 220, 220, 8, 7, 1'b0, 1'b0));
        send_pixel(pixel_of(220, 220, 220, 220, 220, 220, 2, 0, 1'b0, 1'b1));
        settle_pipeline();
    endtask

    // A zero motion limit leaves every pixel counted as moving.
    task automatic test_zero_limit();
        apply_settings(8'd0, CNT_W'(100), COORD_W'(75));
        send_pixel(pixel_of(64, 64, 64, 64, 64, 64, 1, 1, 1'b1, 1'b0));
        send_pixel(pixel_of(230, 230, 230, 230, 230, 230, 2, 2, 1'b0, 1'b1));
        settle_pipeline();
    endtask

    // Random frames under one register setting and one idling pattern. Most
    // frames are well formed (start flag, a run of pixels, end flag); a few
    // miss the start flag and a few words carry random flags.
    task automatic run_random_frames(input int idle_pct, input int stall_pct,
                                     input logic [7:0] limit,
                                     input logic [CNT_W-1:0] anchor,
                                     input logic [COORD_W-1:0] skip, input int quota);
        int     start_count;
        int     frame_len;
        bit     opened;
        bit     ended;
        pixel_t p;
        apply_settings(limit, anchor, skip);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        start_count    = pixels_sent;
        ended          = 1'b1;
        while (pixels_sent - start_count < quota) begin
            frame_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                    : $urandom_range(1, 24);
            opened    = ($urandom_range(0, 19) != 0);
            for (int i = 0; i < frame_len; i++) begin
                p = random_pixel();
                p.frame_first = (i == 0) && opened;
                p.frame_last  = (i == frame_len - 1);
                if ($urandom_range(0, 19) == 0) begin
                    p.frame_first = 1'($urandom_range(0, 1));
                    p.frame_last  = 1'($urandom_range(0, 1));
                end
                send_pixel(p);
                ended = p.frame_last;
            end
        end
        // Close the phase on a frame end so that the drain below covers every
        // pixel that was sent.
        if (!ended) begin
            p = random_pixel();
            p.frame_last = 1'b1;
            send_pixel(p);
        end
        settle_pipeline();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    initial begin
        logic [7:0]         mixed_limit;
        logic [CNT_W-1:0]   mixed_anchor;
        logic [COORD_W-1:0] mixed_skip;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_MOTION_LIMIT;
        cfg_data       = '0;
        pix_if.valid   = 1'b0;
        pix_if.data    = '0;
        res_if.ready   = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_class_picks();
        test_anchor_positions();
        test_zero_limit();

        // Random phases step through the idling patterns and through the
        // register extremes: limits of one and 255, anchor counts of zero and
        // 1048576, row skips of zero and 1023.
        mixed_limit  = 8'($urandom_range(2, 254));
        mixed_anchor = CNT_W'($urandom_range(0, 6));
        mixed_skip   = COORD_W'($urandom_range(0, 12));
        run_random_frames(0, 0, 8'd30, CNT_W'(3), COORD_W'(2), 260);
        run_random_frames(45, 0, 8'd255, CNT_W'(0), COORD_W'(0), 250);
        run_random_frames(0, 45, 8'd1, CNT_W'(1048576), COORD_W'(1023), 250);
        run_random_frames(21, 21, mixed_limit, mixed_anchor, mixed_skip, 250);
        run_random_frames(0, 0, 8'd100, CNT_W'(2), COORD_W'(5), 240);

        $display("Sent %0d pixel words under %0d register settings and four idling patterns.",
                 pixels_sent, settings_applied);
        $display("Checked %0d frame totals words field by field, %0d mismatches.",
                 totals_checked, mismatches);
        if (mismatches == 0) begin
            $display("motion_gated_color_class_counter_unit verification clean");
        end
        else begin
            $display("motion_gated_color_class_counter_unit verification failed");
        end
        $finish;
    end

endmodule
